// ===== rtl/oamm_pkg.sv =====
// ----------------------------------------------------------------------------
// oamm_pkg
// Types, codes and control store for the open-address multiset with a
// running maximum.
// ----------------------------------------------------------------------------
`default_nettype none

package oamm_pkg;

    localparam int VAL_W           = 31;
    localparam int SLOT_W          = 33;
    localparam int DEF_TABLE_SLOTS = 64;

    typedef enum logic [1:0] {
        TAG_EMPTY = 2'd0,
        TAG_TOMB  = 2'd1,
        TAG_FULL  = 2'd2
    } t_tag;

    typedef struct packed {
        t_tag             tag;
        logic [VAL_W-1:0] value;
    } t_slot;

    typedef enum logic [1:0] {
        ST_DONE      = 2'd0,
        ST_TBL_FULL  = 2'd1,
        ST_NOT_FOUND = 2'd2
    } t_status;

    // sequencer steps
    typedef enum logic [3:0] {
        U_CLR,
        U_IDLE,
        U_MOD,
        U_PRB_RD,
        U_PRB_CHK,
        U_PRB_MISS,
        U_WR,
        U_SCAN,
        U_SCAN_END,
        U_FAIL,
        U_RESULT
    } t_upc;

    typedef enum logic [2:0] {
        C_ALWAYS,
        C_IN_ACC,
        C_CNT_LAST,
        C_MOD_LAST,
        C_HIT,
        C_STEP_LAST,
        C_DEL_MAX,
        C_OUT_FREE
    } t_cond;

    typedef enum logic [1:0] {
        A_CNT,
        A_HOME,
        A_POS,
        A_POS_NXT
    } t_asel;

    typedef enum logic [1:0] {
        CNT_HOLD,
        CNT_CLR,
        CNT_INC
    } t_cnt_op;

    typedef enum logic [1:0] {
        POS_HOLD,
        POS_HOME,
        POS_NXT
    } t_pos_op;

    typedef enum logic [1:0] {
        MAX_HOLD,
        MAX_INS,
        MAX_SCAN
    } t_max_op;

    typedef enum logic [1:0] {
        STO_HOLD,
        STO_DONE,
        STO_FAIL
    } t_st_op;

    typedef struct packed {
        logic    in_rdy;
        logic    ld_item;
        logic    mod_en;
        logic    ram_we;
        logic    wr_item;
        t_asel   asel;
        t_cnt_op cnt_op;
        t_pos_op pos_op;
        logic    scan_clr;
        logic    acc_en;
        t_max_op max_op;
        t_st_op  st_op;
        logic    out_ld;
        t_cond   cond;
        t_upc    jmp;
        t_upc    nxt;
    } t_uword;

    typedef struct packed {
        logic in_acc;
        logic cnt_last;
        logic mod_last;
        logic hit;
        logic step_last;
        logic del_max;
        logic out_free;
    } t_flags;

    function automatic t_uword ucode(input t_upc pc);
        t_uword w;
        w = '{in_rdy: 1'b0, ld_item: 1'b0, mod_en: 1'b0, ram_we: 1'b0,
              wr_item: 1'b0, asel: A_POS, cnt_op: CNT_HOLD, pos_op: POS_HOLD,
              scan_clr: 1'b0, acc_en: 1'b0, max_op: MAX_HOLD, st_op: STO_HOLD,
              out_ld: 1'b0, cond: C_ALWAYS, jmp: U_IDLE, nxt: U_IDLE};
        unique case (pc)
            U_CLR: begin
                w.ram_we = 1'b1;
                w.asel   = A_CNT;
                w.cnt_op = CNT_INC;
                w.cond   = C_CNT_LAST;
                w.jmp    = U_IDLE;
                w.nxt    = U_CLR;
            end
            U_IDLE: begin
                w.in_rdy  = 1'b1;
                w.ld_item = 1'b1;
                w.cnt_op  = CNT_CLR;
                w.cond    = C_IN_ACC;
                w.jmp     = U_MOD;
                w.nxt     = U_IDLE;
            end
            U_MOD: begin
                w.mod_en = 1'b1;
                w.cnt_op = CNT_INC;
                w.cond   = C_MOD_LAST;
                w.jmp    = U_PRB_RD;
                w.nxt    = U_MOD;
            end
            U_PRB_RD: begin
                w.asel   = A_HOME;
                w.pos_op = POS_HOME;
                w.cond   = C_ALWAYS;
                w.jmp    = U_PRB_CHK;
            end
            U_PRB_CHK: begin
                w.cond = C_HIT;
                w.jmp  = U_WR;
                w.nxt  = U_PRB_MISS;
            end
            U_PRB_MISS: begin
                w.asel   = A_POS_NXT;
                w.pos_op = POS_NXT;
                w.cond   = C_STEP_LAST;
                w.jmp    = U_FAIL;
                w.nxt    = U_PRB_CHK;
            end
            U_WR: begin
                w.ram_we   = 1'b1;
                w.wr_item  = 1'b1;
                w.asel     = A_POS;
                w.max_op   = MAX_INS;
                w.st_op    = STO_DONE;
                w.cnt_op   = CNT_CLR;
                w.scan_clr = 1'b1;
                w.cond     = C_DEL_MAX;
                w.jmp      = U_SCAN;
                w.nxt      = U_RESULT;
            end
            U_SCAN: begin
                w.asel   = A_CNT;
                w.cnt_op = CNT_INC;
                w.acc_en = 1'b1;
                w.cond   = C_CNT_LAST;
                w.jmp    = U_SCAN_END;
                w.nxt    = U_SCAN;
            end
            U_SCAN_END: begin
                w.acc_en = 1'b1;
                w.max_op = MAX_SCAN;
                w.jmp    = U_RESULT;
            end
            U_FAIL: begin
                w.st_op = STO_FAIL;
                w.jmp   = U_RESULT;
            end
            U_RESULT: begin
                w.out_ld = 1'b1;
                w.cond   = C_OUT_FREE;
                w.jmp    = U_IDLE;
                w.nxt    = U_RESULT;
            end
            default: begin
                w.jmp = U_IDLE;
                w.nxt = U_IDLE;
            end
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/oamm_if.sv =====
// ----------------------------------------------------------------------------
// oamm_if
// Valid/ready channels for commands and responses of the multiset.
// ----------------------------------------------------------------------------
`default_nettype none

interface oamm_cmd_if;
    import oamm_pkg::*;
    logic             valid;
    logic             ready;
    logic             command;
    logic [VAL_W-1:0] item_value;
    modport source (output valid, output command, output item_value, input ready);
    modport sink   (input valid, input command, input item_value, output ready);
endinterface

interface oamm_rsp_if;
    import oamm_pkg::*;
    logic             valid;
    logic             ready;
    t_status          status;
    logic [VAL_W-1:0] current_max;
    modport source (output valid, output status, output current_max, input ready);
    modport sink   (input valid, input status, input current_max, output ready);
endinterface

`default_nettype wire

// ===== rtl/oamm_ram.sv =====
// ----------------------------------------------------------------------------
// oamm_ram
// Generic single-clock RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module oamm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ===== rtl/oamm_seq.sv =====
// ----------------------------------------------------------------------------
// oamm_seq
// Step counter and control store; picks the jump or the next step from the
// condition named in the current control word.
// ----------------------------------------------------------------------------
`default_nettype none

module oamm_seq (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire oamm_pkg::t_flags i_flags,
    output oamm_pkg::t_uword     o_uword,
    output oamm_pkg::t_upc       o_upc
);
    import oamm_pkg::*;

    t_upc r_upc;
    t_upc n_upc;
    logic taken;

    always_comb begin
        o_uword = ucode(r_upc);
        o_upc   = r_upc;
    end

    always_comb begin
        unique case (o_uword.cond)
            C_ALWAYS:    taken = 1'b1;
            C_IN_ACC:    taken = i_flags.in_acc;
            C_CNT_LAST:  taken = i_flags.cnt_last;
            C_MOD_LAST:  taken = i_flags.mod_last;
            C_HIT:       taken = i_flags.hit;
            C_STEP_LAST: taken = i_flags.step_last;
            C_DEL_MAX:   taken = i_flags.del_max;
            C_OUT_FREE:  taken = i_flags.out_free;
            default:     taken = 1'b1;
        endcase
        n_upc = taken ? o_uword.jmp : o_uword.nxt;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upc <= U_CLR;
        end else begin
            r_upc <= n_upc;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/open_address_multiset_with_max.sv =====
// ----------------------------------------------------------------------------
// open_address_multiset_with_max
// Hash multiset with triangular probing, tombstones and a running maximum.
// The home slot is computed by reciprocal multiplication in the mod steps,
// and each probe waits on the registered slot RAM read; a delete of the
// maximum adds a rescan of the slot RAM to find the new maximum.
// One command at a time; the next is taken once the response is registered.
// Reset: a clearing pass over every slot empties the slot RAM.
// ----------------------------------------------------------------------------
`default_nettype none

module open_address_multiset_with_max #(
    parameter int TABLE_SLOTS = oamm_pkg::DEF_TABLE_SLOTS
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    oamm_cmd_if.sink   i_cmd,
    oamm_rsp_if.source o_rsp
);
    import oamm_pkg::*;

    localparam int AW = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
    localparam int RW = AW + 1;
    localparam int CW = (AW > 5) ? AW : 5;

    localparam int          MOD_STEPS = 3;
    localparam int          PROD_W    = 64;
    localparam int          MOD_SH    = VAL_W + $clog2(TABLE_SLOTS);
    localparam logic [63:0] MOD_RCP   =
        ((64'd1 << MOD_SH) + 64'(TABLE_SLOTS) - 64'd1) / 64'(TABLE_SLOTS);
    localparam logic [15:0] RCP_LO    = MOD_RCP[15:0];
    localparam logic [16:0] RCP_HI    = MOD_RCP[32:16];

    t_uword uw;
    t_upc   upc;
    t_flags flags;

    logic              r_cmd;
    logic [VAL_W-1:0]  r_val;
    logic [PROD_W-1:0] r_prod;
    logic [RW-1:0]     r_rem;
    logic [AW-1:0]     r_pos;
    logic [AW-1:0]     r_step;
    logic [CW-1:0]     r_cnt;
    logic [VAL_W-1:0]  r_max;
    logic [VAL_W-1:0]  r_scan;
    logic              r_rd_live;
    t_status           r_status;
    logic              r_out_valid;
    t_status           r_out_status;
    logic [VAL_W-1:0]  r_out_max;

    logic [VAL_W+15:0] mul_lo;
    logic [VAL_W+16:0] mul_hi;
    logic [RW-1:0]     n_rem;
    logic [AW:0]      pos_sum;
    logic [AW:0]      pos_wrap;
    logic [AW-1:0]    pos_nxt;
    logic [VAL_W-1:0] n_scan;
    logic [AW-1:0]    ram_addr;
    t_slot            ram_wdata;
    logic [SLOT_W-1:0] ram_rdata;
    t_slot            rd;
    logic             in_acc;
    logic             out_free;
    logic             hit;

    assign rd       = t_slot'(ram_rdata);
    assign in_acc   = i_cmd.valid && uw.in_rdy;
    assign out_free = !r_out_valid || o_rsp.ready;

    // home slot by reciprocal multiplication, split over the mod steps
    always_comb begin
        mul_lo = {16'b0, r_val} * {{VAL_W{1'b0}}, RCP_LO};
        mul_hi = {17'b0, r_val} * {{VAL_W{1'b0}}, RCP_HI};
        n_rem  = r_val[RW-1:0] - r_prod[MOD_SH +: RW] * RW'(TABLE_SLOTS);
    end

    always_comb begin
        pos_sum  = {1'b0, r_pos} + {1'b0, r_step} + (AW+1)'(1);
        pos_wrap = pos_sum - (AW+1)'(TABLE_SLOTS);
        pos_nxt  = (pos_sum >= (AW+1)'(TABLE_SLOTS)) ? pos_wrap[AW-1:0] : pos_sum[AW-1:0];
    end

    always_comb begin
        if (r_cmd) begin
            hit = (rd.tag == TAG_FULL) && (rd.value == r_val);
        end else begin
            hit = (rd.tag != TAG_FULL);
        end
    end

    always_comb begin
        if (uw.acc_en && r_rd_live && rd.tag == TAG_FULL && rd.value > r_scan) begin
            n_scan = rd.value;
        end else begin
            n_scan = r_scan;
        end
    end

    always_comb begin
        unique case (uw.asel)
            A_CNT:     ram_addr = r_cnt[AW-1:0];
            A_HOME:    ram_addr = r_rem[AW-1:0];
            A_POS:     ram_addr = r_pos;
            A_POS_NXT: ram_addr = pos_nxt;
            default:   ram_addr = r_pos;
        endcase
        if (!uw.wr_item) begin
            ram_wdata = '{tag: TAG_EMPTY, value: '0};
        end else if (r_cmd) begin
            ram_wdata = '{tag: TAG_TOMB, value: '0};
        end else begin
            ram_wdata = '{tag: TAG_FULL, value: r_val};
        end
    end

    always_comb begin
        flags.in_acc    = in_acc;
        flags.cnt_last  = (r_cnt == CW'(TABLE_SLOTS - 1));
        flags.mod_last  = (r_cnt == CW'(MOD_STEPS - 1));
        flags.hit       = hit;
        flags.step_last = (r_step == AW'(TABLE_SLOTS - 1));
        flags.del_max   = r_cmd && (r_val == r_max);
        flags.out_free  = out_free;
    end

    oamm_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_flags (flags),
        .o_uword (uw),
        .o_upc   (upc)
    );

    oamm_ram #(
        .WIDTH (SLOT_W),
        .DEPTH (TABLE_SLOTS)
    ) u_slots (
        .i_clk   (i_clk),
        .i_we    (uw.ram_we),
        .i_waddr (ram_addr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_addr),
        .o_rdata (ram_rdata)
    );

    // payload
    always_ff @(posedge i_clk) begin
        if (uw.ld_item && in_acc) begin
            r_cmd <= i_cmd.command;
            r_val <= i_cmd.item_value;
        end else if (uw.mod_en) begin
            if (r_cnt == CW'(0)) begin
                r_prod <= {17'b0, mul_lo};
            end else if (r_cnt == CW'(1)) begin
                r_prod <= r_prod + {mul_hi, 16'b0};
            end else begin
                r_rem <= n_rem;
            end
        end
        unique case (uw.pos_op)
            POS_HOME: begin
                r_pos  <= r_rem[AW-1:0];
                r_step <= '0;
            end
            POS_NXT: begin
                r_pos  <= pos_nxt;
                r_step <= r_step + AW'(1);
            end
            default: begin
                r_pos  <= r_pos;
                r_step <= r_step;
            end
        endcase
        r_scan <= uw.scan_clr ? '0 : n_scan;
        unique case (uw.st_op)
            STO_DONE: r_status <= ST_DONE;
            STO_FAIL: r_status <= r_cmd ? ST_NOT_FOUND : ST_TBL_FULL;
            default:  r_status <= r_status;
        endcase
        if (uw.out_ld && out_free) begin
            r_out_status <= r_status;
            r_out_max    <= r_max;
        end
    end

    // control and kept state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt       <= '0;
            r_max       <= '0;
            r_rd_live   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            unique case (uw.cnt_op)
                CNT_CLR: r_cnt <= '0;
                CNT_INC: r_cnt <= r_cnt + CW'(1);
                default: r_cnt <= r_cnt;
            endcase
            unique case (uw.max_op)
                MAX_INS:  r_max <= (!r_cmd && r_val > r_max) ? r_val : r_max;
                MAX_SCAN: r_max <= n_scan;
                default:  r_max <= r_max;
            endcase
            r_rd_live <= (upc == U_SCAN);
            if (uw.out_ld && out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign i_cmd.ready       = uw.in_rdy;
    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.status      = r_out_status;
    assign o_rsp.current_max = r_out_max;

    a_acc_starts_mod: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> (upc == U_MOD))
        else $error("command transaction did not start the remainder");

    a_home_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (upc == U_PRB_RD) |-> (r_rem < RW'(TABLE_SLOTS)))
        else $error("home slot out of range");

    a_write_after_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (upc == U_WR) |-> ($past(upc) == U_PRB_CHK && $past(hit)))
        else $error("slot write without a probe hit");

    a_fail_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (upc == U_FAIL) |-> ($past(upc) == U_PRB_MISS && $past(r_step) == AW'(TABLE_SLOTS - 1)))
        else $error("probe gave up early");

    a_result_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (upc == U_RESULT && out_free) |=> (r_out_valid && upc == U_IDLE))
        else $error("response not registered");

endmodule

`default_nettype wire
